@@ hdl/qrs_pkg.sv @@
// Package for the quadratic root solver: root class codes and fixed widths.
// No dependencies.
package qrs_pkg;

  localparam int OUT_W = 41;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_DEGEN  = 3'd1,
    KIND_LINEAR = 3'd2,
    KIND_DOUBLE = 3'd3,
    KIND_TWO    = 3'd4
  } kind_t;

endpackage

@@ hdl/qrs_front.sv @@
// Front end: accepts coefficient sets, forms the discriminant and the root class.
// Depends on qrs_pkg.
module qrs_front #(
  parameter int CB = 16,
  parameter int FB = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [CB-1:0]  in_a,
  input  logic signed [CB-1:0]  in_b,
  input  logic signed [CB-1:0]  in_c,
  output logic                  push,
  input  logic                  full,
  output qrs_pkg::kind_t        kind,
  output logic signed [CB+FB:0] base,
  output logic signed [CB+1:0]  den,
  output logic [2*CB:0]         disc
);
  import qrs_pkg::*;

  localparam int XW = 2 * CB + 2;

  logic                   v_r;
  logic signed [CB-1:0]   a_r, b_r, c_r;
  logic signed [2*CB-1:0] bb_r, ac_r;
  logic signed [XW-1:0]   dsc;
  logic signed [CB:0]     neg_b, neg_c;

  assign in_ready = !v_r || !full;
  assign push     = v_r && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_r  <= in_a;
      b_r  <= in_b;
      c_r  <= in_c;
      bb_r <= in_b * in_b;
      ac_r <= in_a * in_c;
    end
  end

  always_comb begin
    dsc   = XW'(bb_r) - (XW'(ac_r) <<< 2);
    neg_b = -(CB+1)'(b_r);
    neg_c = -(CB+1)'(c_r);
    disc  = '0;
    if (a_r == '0) begin
      base = (CB+FB+1)'(neg_c) <<< FB;
      den  = (CB+2)'(b_r);
      kind = (b_r == '0) ? KIND_DEGEN : KIND_LINEAR;
    end else begin
      base = (CB+FB+1)'(neg_b) <<< FB;
      den  = (CB+2)'(a_r) <<< 1;
      if (dsc == '0) begin
        kind = KIND_DOUBLE;
      end else if (dsc[XW-1]) begin
        kind = KIND_NONE;
      end else begin
        kind = KIND_TWO;
        disc = dsc[2*CB:0];
      end
    end
  end

endmodule

@@ hdl/qrs_queue.sv @@
// Short queue between the front end and the arithmetic back end.
// Depends on qrs_pkg.
module qrs_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);
  import qrs_pkg::*;

  logic [W-1:0]        mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QPTR_W:0]     cnt_r;

  assign full       = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

@@ hdl/qrs_sqrt_pipe.sv @@
// Pipelined digit-by-digit square root, one root bit per stage, with sideband.
// Depends on qrs_pkg.
module qrs_sqrt_pipe #(
  parameter int SW = 33,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*SW-1:0] in_rad,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [SW-1:0]   out_root,
  output logic [PW-1:0]   out_pay
);
  import qrs_pkg::*;

  logic            v_r    [SW];
  logic [SW-1:0]   rem_r  [SW];
  logic [SW-1:0]   root_r [SW];
  logic [2*SW-1:0] rad_r  [SW];
  logic [PW-1:0]   pay_r  [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic            v_in;
    logic [SW-1:0]   rem_in, root_in;
    logic [2*SW-1:0] rad_in;
    logic [PW-1:0]   pay_in;
    logic [SW+1:0]   remsh, trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign pay_in  = in_pay;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign pay_in  = pay_r[i-1];
    end

    assign remsh = {rem_in, rad_in[2*SW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? SW'(remsh - trial) : SW'(remsh);
        root_r[i] <= {root_in[SW-2:0], ge};
        rad_r[i]  <= rad_in << 2;
        pay_r[i]  <= pay_in;
      end
    end
  end

  assign out_valid = v_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_pay   = pay_r[SW-1];

endmodule

@@ hdl/qrs_div_pipe.sv @@
// Pipelined restoring divider, two dividends over one shared divisor, one bit a stage.
// Depends on qrs_pkg.
module qrs_div_pipe #(
  parameter int NB = 34,
  parameter int DB = 17,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NB-1:0] in_n1,
  input  logic [NB-1:0] in_n2,
  input  logic [DB-1:0] in_d,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NB-1:0] out_q1,
  output logic [NB-1:0] out_q2,
  output logic [PW-1:0] out_pay
);
  import qrs_pkg::*;

  logic          v_r  [NB];
  logic [DB-1:0] r1_r [NB], r2_r [NB];
  logic [NB-1:0] n1_r [NB], n2_r [NB];
  logic [NB-1:0] q1_r [NB], q2_r [NB];
  logic [DB-1:0] d_r  [NB];
  logic [PW-1:0] pay_r[NB];

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic          v_in;
    logic [DB-1:0] r1_in, r2_in, d_in;
    logic [NB-1:0] n1_in, n2_in, q1_in, q2_in;
    logic [PW-1:0] pay_in;
    logic [DB:0]   s1, s2;
    logic          ge1, ge2;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign r1_in  = '0;
      assign r2_in  = '0;
      assign n1_in  = in_n1;
      assign n2_in  = in_n2;
      assign q1_in  = '0;
      assign q2_in  = '0;
      assign d_in   = in_d;
      assign pay_in = in_pay;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign r1_in  = r1_r[i-1];
      assign r2_in  = r2_r[i-1];
      assign n1_in  = n1_r[i-1];
      assign n2_in  = n2_r[i-1];
      assign q1_in  = q1_r[i-1];
      assign q2_in  = q2_r[i-1];
      assign d_in   = d_r[i-1];
      assign pay_in = pay_r[i-1];
    end

    assign s1  = {r1_in, n1_in[NB-1]};
    assign s2  = {r2_in, n2_in[NB-1]};
    assign ge1 = (s1 >= {1'b0, d_in});
    assign ge2 = (s2 >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r1_r[i]  <= ge1 ? DB'(s1 - {1'b0, d_in}) : DB'(s1);
        r2_r[i]  <= ge2 ? DB'(s2 - {1'b0, d_in}) : DB'(s2);
        n1_r[i]  <= n1_in << 1;
        n2_r[i]  <= n2_in << 1;
        q1_r[i]  <= {q1_in[NB-2:0], ge1};
        q2_r[i]  <= {q2_in[NB-2:0], ge2};
        d_r[i]   <= d_in;
        pay_r[i] <= pay_in;
      end
    end
  end

  assign out_valid = v_r[NB-1];
  assign out_q1    = q1_r[NB-1];
  assign out_q2    = q2_r[NB-1];
  assign out_pay   = pay_r[NB-1];

endmodule

@@ hdl/quadratic_root_solver.sv @@
// Quadratic root solver top level: front end, queue, square root and divider pipelines.
// Depends on qrs_pkg, qrs_front, qrs_queue, qrs_sqrt_pipe and qrs_div_pipe.
//
// Takes one coefficient set (a, b, c) per clock while in_ready is high and returns one
// result per set, in order: the root class and up to two roots in signed fixed point with
// FRAC_BITS fraction bits, quotients truncated toward zero and saturated to 41 bits.
// Sustained rate is one item per cycle when nothing stalls. A set passes through the front
// end register, the queue, COEF_BITS+FRAC_BITS+1 square root stages, the numerator
// register, COEF_BITS+FRAC_BITS+2 divider stages and the output register; the back end
// advances as a whole whenever the output register is free or being taken, and a four-entry
// queue lets the front end keep accepting while the back end holds.
module quadratic_root_solver #(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COEF_BITS-1:0]  in_coef_quad,
  input  logic signed [COEF_BITS-1:0]  in_coef_lin,
  input  logic signed [COEF_BITS-1:0]  in_coef_const,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_root_kind,
  output logic signed [qrs_pkg::OUT_W-1:0] out_root_first,
  output logic signed [qrs_pkg::OUT_W-1:0] out_root_second
);
  import qrs_pkg::*;

  localparam int CB  = COEF_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int BW  = CB + FB + 1;   // scaled -b or -c
  localparam int DNW = CB + 2;        // signed divisor
  localparam int DSW = 2 * CB + 1;    // positive discriminant
  localparam int SW  = CB + FB + 1;   // square root width
  localparam int NW  = CB + FB + 3;   // signed numerator
  localparam int ND  = NW - 1;        // numerator magnitude
  localparam int DB  = CB + 1;        // divisor magnitude
  localparam int QW  = 3 + BW + DNW + DSW;
  localparam int SPW = 3 + BW + DNW;

  kind_t                 f_kind;
  logic signed [BW-1:0]  f_base;
  logic signed [DNW-1:0] f_den;
  logic [DSW-1:0]        f_disc;
  logic                  q_push, q_full, q_valid, q_pop;
  logic [QW-1:0]         q_head;
  logic                  en;

  logic                  s_valid;
  logic [SW-1:0]         s_root;
  logic [SPW-1:0]        s_pay;
  logic [2:0]            s_kind;
  logic signed [BW-1:0]  s_base;
  logic signed [DNW-1:0] s_den;

  logic                  p_v_r;
  logic signed [NW-1:0]  p_n1_r, p_n2_r;
  logic signed [DNW-1:0] p_den_r;
  logic [2:0]            p_kind_r;

  logic [ND-1:0]         m1, m2;
  logic [DB-1:0]         md;
  logic [4:0]            d_pay_in, d_pay;
  logic                  d_valid;
  logic [ND-1:0]         d_q1, d_q2;
  logic signed [NW-1:0]  sq1, sq2;
  logic signed [OUT_W-1:0] sat1, sat2;

  logic                  out_valid_r;
  logic [2:0]            kind_r;
  logic signed [OUT_W-1:0] first_r, second_r;

  qrs_front #(.CB(CB), .FB(FB)) u_front (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .in_a(in_coef_quad), .in_b(in_coef_lin), .in_c(in_coef_const),
    .push(q_push), .full(q_full),
    .kind(f_kind), .base(f_base), .den(f_den), .disc(f_disc)
  );

  qrs_queue #(.W(QW)) u_queue (
    .clk, .rst_n,
    .push(q_push), .push_data({f_kind, f_base, f_den, f_disc}), .full(q_full),
    .pop(q_pop), .head_valid(q_valid), .head_data(q_head)
  );

  // whole back end moves together while the output slot frees up
  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  qrs_sqrt_pipe #(.SW(SW), .PW(SPW)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid(q_valid),
    .in_rad({1'b0, q_head[DSW-1:0], {(2*FB){1'b0}}}),
    .in_pay(q_head[QW-1:DSW]),
    .out_valid(s_valid), .out_root(s_root), .out_pay(s_pay)
  );

  assign s_kind = s_pay[SPW-1 -: 3];
  assign s_base = s_pay[BW+DNW-1:DNW];
  assign s_den  = s_pay[DNW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_n1_r   <= NW'(s_base) + $signed({2'b00, s_root});
      p_n2_r   <= NW'(s_base) - $signed({2'b00, s_root});
      p_den_r  <= s_den;
      p_kind_r <= s_kind;
    end
  end

  // magnitudes into the divider, signs ride along
  assign m1 = p_n1_r[NW-1] ? ND'(-p_n1_r) : ND'(p_n1_r);
  assign m2 = p_n2_r[NW-1] ? ND'(-p_n2_r) : ND'(p_n2_r);
  assign md = p_den_r[DNW-1] ? DB'(-p_den_r) : DB'(p_den_r);
  assign d_pay_in = {p_kind_r, p_n1_r[NW-1] ^ p_den_r[DNW-1],
                     p_n2_r[NW-1] ^ p_den_r[DNW-1]};

  qrs_div_pipe #(.NB(ND), .DB(DB), .PW(5)) u_div (
    .clk, .rst_n, .en,
    .in_valid(p_v_r), .in_n1(m1), .in_n2(m2), .in_d(md), .in_pay(d_pay_in),
    .out_valid(d_valid), .out_q1(d_q1), .out_q2(d_q2), .out_pay(d_pay)
  );

  assign sq1 = d_pay[1] ? -$signed({1'b0, d_q1}) : $signed({1'b0, d_q1});
  assign sq2 = d_pay[0] ? -$signed({1'b0, d_q2}) : $signed({1'b0, d_q2});

  if (NW > OUT_W) begin : g_sat
    localparam logic signed [OUT_W-1:0] MAXV = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] MINV = {1'b1, {(OUT_W-1){1'b0}}};
    always_comb begin
      sat1 = sq1[OUT_W-1:0];
      if (!sq1[NW-1] && |sq1[NW-2:OUT_W-1]) sat1 = MAXV;
      if (sq1[NW-1] && !(&sq1[NW-2:OUT_W-1])) sat1 = MINV;
      sat2 = sq2[OUT_W-1:0];
      if (!sq2[NW-1] && |sq2[NW-2:OUT_W-1]) sat2 = MAXV;
      if (sq2[NW-1] && !(&sq2[NW-2:OUT_W-1])) sat2 = MINV;
    end
  end else if (NW == OUT_W) begin : g_same
    assign sat1 = sq1;
    assign sat2 = sq2;
  end else begin : g_ext
    assign sat1 = {{(OUT_W-NW){sq1[NW-1]}}, sq1};
    assign sat2 = {{(OUT_W-NW){sq2[NW-1]}}, sq2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= d_pay[4:2];
      case (kind_t'(d_pay[4:2]))
        KIND_LINEAR: begin
          first_r  <= sat1;
          second_r <= '0;
        end
        KIND_DOUBLE, KIND_TWO: begin
          first_r  <= sat1;
          second_r <= sat2;
        end
        default: begin
          first_r  <= '0;
          second_r <= '0;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_kind   = kind_r;
  assign out_root_first  = first_r;
  assign out_root_second = second_r;

  a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_DOUBLE |-> first_r == second_r)
    else $error("double root with unequal roots");

  a_no_roots_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == KIND_NONE || kind_r == KIND_DEGEN)
      |-> first_r == '0 && second_r == '0)
    else $error("root reported for a rootless class");

  a_linear_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_LINEAR |-> second_r == '0)
    else $error("linear result with second root");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(first_r) && $stable(kind_r))
    else $error("pending result lost");

endmodule
